// ===== rtl/rtpap_pkg.sv =====
// Shared types, codes and helper functions for the RTP audio packetizer.
// No dependencies; the top level and the divider import this package.
`default_nettype none

package rtpap_pkg;

   // Widths fixed by the item fields and registers.
   localparam int LEN_W   = 16;
   localparam int FRAME_W = 8;

   // Request opcodes. Code 3 carries no meaning and is ignored.
   localparam logic [1:0] OP_ADD_SOURCE = 2'd0;
   localparam logic [1:0] OP_START      = 2'd1;
   localparam logic [1:0] OP_PAYLOAD    = 2'd2;

   // Register indexes on the write port.
   localparam logic [2:0] CSR_BIT_DEPTH        = 3'd0;
   localparam logic [2:0] CSR_CHANNEL_COUNT    = 3'd1;
   localparam logic [2:0] CSR_SOURCE_ID        = 3'd2;
   localparam logic [2:0] CSR_SEQUENCE_OFFSET  = 3'd3;
   localparam logic [2:0] CSR_TIMESTAMP_OFFSET = 3'd4;
   localparam logic [2:0] CSR_PAYLOAD_KIND     = 3'd5;

   // RTP version field value placed in the top two header bits.
   localparam logic [1:0] RTP_VERSION = 2'd2;

   // Status of the timestamp divider as seen by the control logic.
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // True when a 16-bit length is a multiple of three. Powers of four are
   // congruent to one modulo three, so the base-4 digits are summed.
   function automatic logic len_mult3(input logic [LEN_W-1:0] len);
      logic [4:0] s;
      logic [2:0] t;
      s = '0;
      for (int i = 0; i < LEN_W / 2; i++) begin
         s = s + 5'(len[2*i +: 2]);
      end
      t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
      return (t == 3'd0) || (t == 3'd3) || (t == 3'd6);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/rtp_audio_packetizer_unit.sv =====
// RTP audio packetizer top level: request decode, header sequencer, payload
// gathering and the result register. Uses rtpap_pkg, rtpap_srcq, rtpap_div.
`default_nettype none

// The block builds RTP version 2 packets one item at a time. A source-id item
// (opcode 0) is queued in a small memory; ids beyond MAX_SOURCES are dropped.
// A start item (opcode 1) with a nonzero length emits three header words and
// then the queued ids, one word per result; the three header words leave one
// per cycle while the result register is free, and each queued id passes
// through a read state and a write state, because the id store is a
// synchronous memory with registered read data that is read one entry at a
// time. A start item also launches a bit-serial divider that computes length /
// (bytes per sample times channels) for the timestamp advance; its quotient is
// folded into the sample count once it signals done, and no further item is
// accepted until the header words and the divider are both done. A start item
// with zero length only clears the queue. A payload item (opcode 2) gives at
// most one result: with 16, 24 or 32 bit samples and a length that is a whole
// number of samples, bytes are gathered into one byte-reversed word per sample,
// and otherwise each byte is passed on alone. Results wait in an output
// register; every item is accepted only when that register is empty or being
// drained in the same cycle. Registers on the csr_ port may be written only
// while the block is idle.
module rtp_audio_packetizer_unit #(
   parameter int MAX_SOURCES = 15
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [31:0] req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_out_word,
   output logic [2:0]       rsp_byte_count,
   output logic             rsp_is_header,
   output logic             rsp_last
);
   import rtpap_pkg::*;

   localparam int CW = $clog2(MAX_SOURCES + 1);
   localparam int AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_HDR  = 4'b0010,
      S_RD   = 4'b0100,
      S_WR   = 4'b1000
   } state_type;

   // Configuration registers.
   logic [5:0]  bit_depth_ff;
   logic [4:0]  channel_count_ff;
   logic [31:0] source_id_ff;
   logic [15:0] seq_off_ff;
   logic [31:0] ts_off_ff;
   logic [6:0]  payload_kind_ff;

   // Packet state.
   state_type      state_ff, state_in;
   logic [CW-1:0]  src_count_ff, src_count_in;
   logic [15:0]    packet_count_ff, packet_count_in;
   logic [31:0]    sample_count_ff, sample_count_in;
   logic [15:0]    bytes_left_ff, bytes_left_in;
   logic           swap_on_ff, swap_on_in;
   logic [23:0]    partial_sample_ff, partial_sample_in;
   logic [1:0]     partial_fill_ff, partial_fill_in;
   logic           hdr_idx_ff, hdr_idx_in;
   logic [31:0]    ts_word_ff, ts_word_in;
   logic [CW-1:0]  list_len_ff, list_len_in;
   logic [CW-1:0]  rd_idx_ff, rd_idx_in;
   logic           frame_zero_ff, frame_zero_in;

   // Result register.
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    rsp_word_ff, rsp_word_in;
   logic [2:0]     rsp_count_ff, rsp_count_in;
   logic           rsp_hdr_ff, rsp_hdr_in;
   logic           rsp_last_ff, rsp_last_in;

   // Combinational helpers.
   logic           out_free;
   logic           accept;
   logic           ld;
   logic [31:0]    ld_word;
   logic [2:0]     ld_count;
   logic           ld_hdr;
   logic           ld_last;
   logic           wr_en;
   logic [31:0]    rd_data;
   logic           div_start;
   logic [LEN_W-1:0]   len_sat;
   logic [FRAME_W-1:0] frame;
   logic [15:0]    seq;
   logic           pay_last;
   logic [2:0]     k_clamp;
   logic [2:0]     fill_p1;
   logic [31:0]    gathered;
   div_stat_type   div_stat;
   logic [LEN_W-1:0]   div_quot;

   rtpap_srcq #(
      .DEPTH (MAX_SOURCES),
      .AW    (AW)
   ) u_srcq (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (src_count_ff[AW-1:0]),
      .wr_data (req_value),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   rtpap_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (len_sat),
      .den   (frame),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   // Writes to the id store happen only while idle and its read data is used only
   // while a header is going out, so the two ports never touch the same entry in
   // overlapping cycles and no forwarding path is needed.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free && !div_stat.busy && !div_stat.done;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in          = state_ff;
      src_count_in      = src_count_ff;
      packet_count_in   = packet_count_ff;
      sample_count_in   = sample_count_ff;
      bytes_left_in     = bytes_left_ff;
      swap_on_in        = swap_on_ff;
      partial_sample_in = partial_sample_ff;
      partial_fill_in   = partial_fill_ff;
      hdr_idx_in        = hdr_idx_ff;
      ts_word_in        = ts_word_ff;
      list_len_in       = list_len_ff;
      rd_idx_in         = rd_idx_ff;
      frame_zero_in     = frame_zero_ff;
      ld                = 1'b0;
      ld_word           = '0;
      ld_count          = 3'd4;
      ld_hdr            = 1'b1;
      ld_last           = 1'b0;
      wr_en             = 1'b0;
      div_start         = 1'b0;

      len_sat  = (|req_value[31:16]) ? {LEN_W{1'b1}} : req_value[LEN_W-1:0];
      frame    = {5'b0, bit_depth_ff[5:3]} * {3'b0, channel_count_ff};
      seq      = packet_count_ff + seq_off_ff;
      pay_last = bytes_left_ff == 16'd1;
      if (bit_depth_ff[5:3] == 3'd0) begin
         k_clamp = 3'd1;
      end else if (bit_depth_ff[5:3] > 3'd4) begin
         k_clamp = 3'd4;
      end else begin
         k_clamp = bit_depth_ff[5:3];
      end
      fill_p1  = {1'b0, partial_fill_ff} + 3'd1;
      gathered = {8'b0, partial_sample_ff} | ({24'b0, req_value[7:0]} << {partial_fill_ff, 3'b0});

      // The divider result lands while the block is still busy with the packet.
      if (div_stat.done && !frame_zero_ff) begin
         sample_count_in = sample_count_ff + {16'b0, div_quot};
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_ADD_SOURCE: begin
                     if (src_count_ff < CW'(MAX_SOURCES)) begin
                        wr_en        = 1'b1;
                        src_count_in = src_count_ff + 1'b1;
                     end
                  end
                  OP_START: begin
                     src_count_in = '0;
                     if (len_sat != '0) begin
                        // First header word goes straight to the result register.
                        ld      = 1'b1;
                        ld_word = {RTP_VERSION, 2'b00, 4'(src_count_ff), 1'b0,
                                   payload_kind_ff, seq};
                        ts_word_in        = sample_count_ff + ts_off_ff;
                        list_len_in       = src_count_ff;
                        packet_count_in   = packet_count_ff + 16'd1;
                        div_start         = 1'b1;
                        frame_zero_in     = frame == '0;
                        bytes_left_in     = len_sat;
                        swap_on_in        = ((bit_depth_ff == 6'd16) && !len_sat[0]) ||
                                            ((bit_depth_ff == 6'd24) && len_mult3(len_sat)) ||
                                            ((bit_depth_ff == 6'd32) && (len_sat[1:0] == 2'b00));
                        partial_sample_in = '0;
                        partial_fill_in   = '0;
                        hdr_idx_in        = 1'b0;
                        rd_idx_in         = '0;
                        state_in          = S_HDR;
                     end
                  end
                  OP_PAYLOAD: begin
                     if (bytes_left_ff != '0) begin
                        bytes_left_in = bytes_left_ff - 16'd1;
                        ld_hdr        = 1'b0;
                        ld_last       = pay_last;
                        if (swap_on_ff) begin
                           if ((fill_p1 >= k_clamp) || pay_last) begin
                              ld                = 1'b1;
                              ld_word           = gathered;
                              ld_count          = fill_p1;
                              partial_sample_in = '0;
                              partial_fill_in   = '0;
                           end else begin
                              partial_sample_in = gathered[23:0];
                              partial_fill_in   = fill_p1[1:0];
                           end
                        end else begin
                           ld       = 1'b1;
                           ld_word  = {24'b0, req_value[7:0]};
                           ld_count = 3'd1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_HDR: begin
            if (out_free) begin
               ld = 1'b1;
               if (!hdr_idx_ff) begin
                  ld_word    = ts_word_ff;
                  hdr_idx_in = 1'b1;
               end else begin
                  ld_word  = source_id_ff;
                  state_in = (list_len_ff == '0) ? S_IDLE : S_RD;
               end
            end
         end
         S_RD: begin
            // The read address is already on the memory; data arrives next cycle.
            state_in = S_WR;
         end
         S_WR: begin
            if (out_free) begin
               ld      = 1'b1;
               ld_word = rd_data;
               if (rd_idx_ff == list_len_ff - 1'b1) begin
                  state_in = S_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + 1'b1;
                  state_in  = S_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = out_free ? ld : rsp_valid_ff;
      rsp_word_in  = ld ? ld_word  : rsp_word_ff;
      rsp_count_in = ld ? ld_count : rsp_count_ff;
      rsp_hdr_in   = ld ? ld_hdr   : rsp_hdr_ff;
      rsp_last_in  = ld ? ld_last  : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_depth_ff      <= 6'd16;
         channel_count_ff  <= 5'd2;
         source_id_ff      <= '0;
         seq_off_ff        <= '0;
         ts_off_ff         <= '0;
         payload_kind_ff   <= 7'd127;
         state_ff          <= S_IDLE;
         src_count_ff      <= '0;
         packet_count_ff   <= '0;
         sample_count_ff   <= '0;
         bytes_left_ff     <= '0;
         swap_on_ff        <= 1'b0;
         partial_sample_ff <= '0;
         partial_fill_ff   <= '0;
         hdr_idx_ff        <= 1'b0;
         list_len_ff       <= '0;
         rd_idx_ff         <= '0;
         frame_zero_ff     <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BIT_DEPTH:        bit_depth_ff     <= csr_wdata[5:0];
               CSR_CHANNEL_COUNT:    channel_count_ff <= csr_wdata[4:0];
               CSR_SOURCE_ID:        source_id_ff     <= csr_wdata;
               CSR_SEQUENCE_OFFSET:  seq_off_ff       <= csr_wdata[15:0];
               CSR_TIMESTAMP_OFFSET: ts_off_ff        <= csr_wdata;
               CSR_PAYLOAD_KIND:     payload_kind_ff  <= csr_wdata[6:0];
               default: begin
               end
            endcase
         end
         state_ff          <= state_in;
         src_count_ff      <= src_count_in;
         packet_count_ff   <= packet_count_in;
         sample_count_ff   <= sample_count_in;
         bytes_left_ff     <= bytes_left_in;
         swap_on_ff        <= swap_on_in;
         partial_sample_ff <= partial_sample_in;
         partial_fill_ff   <= partial_fill_in;
         hdr_idx_ff        <= hdr_idx_in;
         list_len_ff       <= list_len_in;
         rd_idx_ff         <= rd_idx_in;
         frame_zero_ff     <= frame_zero_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      ts_word_ff   <= ts_word_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_count_ff <= rsp_count_in;
      rsp_hdr_ff   <= rsp_hdr_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_word   = rsp_word_ff;
   assign rsp_byte_count = rsp_count_ff;
   assign rsp_is_header  = rsp_hdr_ff;
   assign rsp_last       = rsp_last_ff;

   // Header and source id words never close a packet.
   a_hdr_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_header |-> !rsp_last)
      else $error("header item marked last");

   // Every result carries between one and four bytes.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_count != 3'd0) && (rsp_byte_count <= 3'd4))
      else $error("result byte count out of range");

   // A start item with a nonzero length puts its first header word out at once.
   a_start_header: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode == OP_START) && (req_value != 32'd0)
      |=> rsp_valid && rsp_is_header)
      else $error("start item did not produce a header item");

   // The id queue never grows past its memory.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      src_count_ff <= CW'(MAX_SOURCES))
      else $error("source queue overflow");

endmodule

`default_nettype wire

// ===== rtl/rtpap_srcq.sv =====
// Contributing-source id store: one synchronous memory, one write port and
// one read port with registered read data. Depends on no package.
`default_nettype none

module rtpap_srcq #(
   parameter int DEPTH = 15,
   parameter int AW    = 4
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [31:0]   wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic [31:0]        rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/rtpap_div.sv =====
// Bit-serial restoring divider for the timestamp advance: length / frame size.
// Depends on rtpap_pkg for widths and the status struct.
`default_nettype none

module rtpap_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [rtpap_pkg::LEN_W-1:0]   num,
   input  wire logic [rtpap_pkg::FRAME_W-1:0] den,
   output rtpap_pkg::div_stat_type            stat,
   output logic [rtpap_pkg::LEN_W-1:0]        quot
);
   import rtpap_pkg::*;

   localparam int CNT_W = $clog2(LEN_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [LEN_W-1:0]     num_ff, num_in;
   logic [FRAME_W-1:0]   rem_ff, rem_in;
   logic [FRAME_W-1:0]   den_ff, den_in;
   logic [FRAME_W:0]     shifted;
   logic                 ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      shifted = {rem_ff, num_ff[LEN_W-1]};
      ge      = shifted >= {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         // The quotient bits shift in where the dividend bits shift out.
         num_in = {num_ff[LEN_W-2:0], ge};
         rem_in = ge ? FRAME_W'(shifted - {1'b0, den_ff}) : FRAME_W'(shifted);
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(LEN_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = num_ff;

endmodule

`default_nettype wire
